/* hw/rtl/sclse_pkg.sv */
// Shared types and constants for the sparse column log-sum-exp block.
`timescale 1ns / 1ps
`default_nettype none
package sclse_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ACC_WIDTH_DEF = 64;

  // log2(e) and ln(2) in Q30.
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [31:0] ONE_Q30   = 32'd1073741824;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] offset;
    logic               last;
    logic               empty_column;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sum_out;
    logic               minus_infinity;
  } out_t;

  // Coefficients of the 2^x polynomial in Q30, lowest order first.
  function automatic logic [31:0] exp_coef(input logic [2:0] idx);
    logic [31:0] c;
    case (idx)
      3'd0:    c = 32'd744261118;
      3'd1:    c = 32'd257941248;
      3'd2:    c = 32'd59596083;
      3'd3:    c = 32'd10327388;
      3'd4:    c = 32'd1431680;
      3'd5:    c = 32'd165394;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/sclse_fifo.sv */
// Two-entry register queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module sclse_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic             empty_o,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

endmodule
`default_nettype wire

/* hw/rtl/sclse_front.sv */
// Front end: accepts entries and computes the exponential term of each.
`timescale 1ns / 1ps
`default_nettype none
module sclse_front import sclse_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push,
  output      logic                   full,
  input  wire in_t                    data_i,
  output      logic                   q_push_o,
  output      logic [ACC_WIDTH+32:0]  q_data_o,
  input  wire logic                   q_full_i
);

  localparam int TB = FRAC_BITS + 30;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_POLY = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]            state_q, state_d;
  logic signed [32:0]    d_q;
  logic signed [63:0]    t_q;
  logic [31:0]           p_q, p_d;
  logic [2:0]            cnt_q;
  logic [ACC_WIDTH-1:0]  term_d;
  logic signed [31:0]    off_q;
  logic                  close_q, empty_q;
  logic [29:0]           x;
  logic [61:0]           prod;
  logic signed [35:0]    sh;
  logic signed [35:0]    rsh;
  logic [ACC_WIDTH-1:0]  p_ext;

  assign x     = t_q[TB-1:FRAC_BITS];
  assign prod  = p_q * {2'b0, x};
  assign sh    = 36'(signed'(t_q[63:TB])) + 36'(FRAC_BITS) - 36'sd30;
  assign rsh   = -sh;
  assign p_ext = ACC_WIDTH'(p_q);
  assign full  = (state_q != F_IDLE);

  always_comb begin
    p_d = p_q;
    if (cnt_q == 3'd5) p_d = ONE_Q30 + 32'(prod[61:30]);
    else               p_d = exp_coef(3'd4 - cnt_q) + 32'(prod[61:30]);
  end

  // Scale the mantissa by 2^sh; a term too large for the accumulator saturates.
  always_comb begin
    if (empty_q) begin
      term_d = '0;
    end else if (sh >= 36'(ACC_WIDTH - 30)) begin
      term_d = '1;
    end else if (sh >= 0) begin
      term_d = p_ext << sh[5:0];
    end else if (rsh >= 36'sd31) begin
      term_d = '0;
    end else begin
      term_d = p_ext >> rsh[4:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (push) state_d = data_i.empty_column ? F_PUSH : F_MUL;
      F_MUL:  state_d = F_POLY;
      F_POLY: if (cnt_q == 3'd5) state_d = F_PUSH;
      F_PUSH: if (!q_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= F_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        d_q     <= 33'(data_i.value) - 33'(data_i.offset);
        off_q   <= data_i.offset;
        close_q <= data_i.last || data_i.empty_column;
        empty_q <= data_i.empty_column;
      end
      F_MUL: begin
        t_q   <= 64'(d_q) * 64'(signed'({1'b0, LOG2E_Q30}));
        p_q   <= exp_coef(3'd5);
        cnt_q <= 3'd0;
      end
      F_POLY: begin
        p_q   <= p_d;
        cnt_q <= cnt_q + 3'd1;
      end
      default: ;
    endcase
  end

  assign q_push_o = (state_q == F_PUSH);
  assign q_data_o = {term_d, off_q, close_q};

endmodule
`default_nettype wire

/* hw/rtl/sclse_back.sv */
// Back end: accumulates terms and computes the closing logarithm.
`timescale 1ns / 1ps
`default_nettype none
module sclse_back import sclse_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_empty_i,
  input  wire logic [ACC_WIDTH+32:0] q_data_i,
  output      logic                  q_pop_o,
  output      logic                  empty,
  input  wire logic                  pop,
  output      out_t                  data_o
);

  localparam int S = 30 - FRAC_BITS;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_CHK  = 3'd1;
  localparam logic [2:0] B_NORM = 3'd2;
  localparam logic [2:0] B_SQ   = 3'd3;
  localparam logic [2:0] B_MUL  = 3'd4;
  localparam logic [2:0] B_ADD  = 3'd5;
  localparam logic [2:0] B_RND  = 3'd6;
  localparam logic [2:0] B_OUT  = 3'd7;

  logic [2:0]            state_q;
  logic [ACC_WIDTH-1:0]  acc_q, z_q, term, sat_sum;
  logic [ACC_WIDTH:0]    raw_sum;
  logic signed [31:0]    off_in, off_q;
  logic                  close_in;
  logic [6:0]            m_q;
  logic [30:0]           zm_q;
  logic [29:0]           frac_q;
  logic [4:0]            cnt_q;
  logic [61:0]           sq;
  logic [31:0]           sq_hi;
  logic signed [39:0]    mi_q, lq_q, ln_q, ln_d;
  logic [29:0]           pf_q;
  logic [59:0]           pf_prod;
  logic [39:0]           mag;
  logic signed [40:0]    r;
  out_t                  res_q, out_q, out_d;
  logic                  valid_q, out_free;

  assign {term, off_in, close_in} = q_data_i;
  assign raw_sum  = {1'b0, acc_q} + {1'b0, term};
  assign sat_sum  = raw_sum[ACC_WIDTH] ? '1 : raw_sum[ACC_WIDTH-1:0];
  assign q_pop_o  = (state_q == B_IDLE) && !q_empty_i;
  assign sq       = zm_q * zm_q;
  assign sq_hi    = sq[61:30];
  assign pf_prod  = frac_q * LN2_Q30;
  assign mag      = lq_q[39] ? 40'(-lq_q) : 40'(lq_q);
  assign ln_d     = lq_q[39] ? -40'((mag + 40'(1 << (S - 1))) >> S)
                             :  40'((mag + 40'(1 << (S - 1))) >> S);
  assign r        = 41'(ln_q) + 41'(off_q);
  assign out_free = !valid_q || pop;
  assign empty    = !valid_q;
  assign data_o   = out_q;

  // Final result with the offset added and the value saturated.
  always_comb begin
    out_d = res_q;
    if (!res_q.minus_infinity) begin
      if (r > 41'sd2147483647)       out_d.sum_out = 32'sh7fffffff;
      else if (r < -41'sd2147483648) out_d.sum_out = 32'sh80000000;
      else                           out_d.sum_out = r[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      acc_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (state_q == B_OUT && out_free) valid_q <= 1'b1;
      else if (pop && valid_q)          valid_q <= 1'b0;
      case (state_q)
        B_IDLE: if (!q_empty_i) begin
          acc_q <= close_in ? '0 : sat_sum;
          if (close_in) state_q <= B_CHK;
        end
        B_CHK:  state_q <= (z_q == '0) ? B_OUT : B_NORM;
        B_NORM: if (z_q[ACC_WIDTH-1]) state_q <= B_SQ;
        B_SQ:   if (cnt_q == 5'd29) state_q <= B_MUL;
        B_MUL:  state_q <= B_ADD;
        B_ADD:  state_q <= B_RND;
        B_RND:  state_q <= B_OUT;
        B_OUT:  if (out_free) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        z_q   <= sat_sum;
        off_q <= off_in;
        m_q   <= 7'(ACC_WIDTH - 1);
      end
      B_CHK: begin
        res_q.sum_out        <= '0;
        res_q.minus_infinity <= 1'b1;
      end
      B_NORM: begin
        if (z_q[ACC_WIDTH-1]) begin
          zm_q   <= z_q[ACC_WIDTH-1:ACC_WIDTH-31];
          frac_q <= '0;
          cnt_q  <= '0;
        end else begin
          z_q <= z_q << 1;
          m_q <= m_q - 7'd1;
        end
      end
      B_SQ: begin
        cnt_q <= cnt_q + 5'd1;
        if (sq_hi[31]) begin
          zm_q <= sq_hi[31:1];
          frac_q[5'd29 - cnt_q] <= 1'b1;
        end else begin
          zm_q <= sq_hi[30:0];
        end
      end
      B_MUL: begin
        pf_q <= pf_prod[59:30];
        mi_q <= 40'(signed'({1'b0, m_q}) - 8'(FRAC_BITS)) * 40'(signed'({1'b0, LN2_Q30}));
      end
      B_ADD: lq_q <= mi_q + 40'(pf_q);
      B_RND: begin
        ln_q <= ln_d;
        res_q.minus_infinity <= 1'b0;
      end
      default: ;
    endcase
    if (state_q == B_OUT && out_free) out_q <= out_d;
  end

endmodule
`default_nettype wire

/* hw/rtl/sparse_column_log_sum_exp.sv */
// Top level of the sparse column log-sum-exp block.
//
// Usage: one input transaction per stored entry of a sparse column, in
// column order, each carrying the entry value and the column offset in
// Q15.16. The input side is a queue: a transaction is taken when push is
// high and full is low. The item with last set, or an empty-column item,
// closes the column and produces one result transaction with
// ln(sum of exp(value - offset)) + offset, or the minus-infinity flag when
// the sum is zero. Results are read as from a queue: data_o is valid while
// empty is low and is taken when pop is high.
// The front works through each entry in turn (one multiply, six polynomial
// steps, one push that waits while the queue is full), or goes straight to
// the push for an empty-column item, and takes no new entry before it is done.
// The back adds each term as it pops it; a closing transaction then goes
// through normalization, 30 squaring rounds, and scaling and rounding. A
// two-entry queue lets the front work on the next entry while the back is busy.
// Reset clears the accumulator, the queue and the result valid flag. When
// the receiver stalls, the finished result stays in place and the back, then
// the queue and the front, fill up and raise full.
`timescale 1ns / 1ps
`default_nettype none
module sparse_column_log_sum_exp import sclse_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push,
  output      logic full,
  input  wire in_t  data_i,
  output      logic empty,
  input  wire logic pop,
  output      out_t data_o
);

  logic                  fifo_push, fifo_full, fifo_pop, fifo_empty;
  logic [ACC_WIDTH+32:0] fifo_wdata, fifo_rdata;

  sclse_front #(.FRAC_BITS(FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)) u_front (
    .clk_i, .rst_ni, .push, .full, .data_i,
    .q_push_o(fifo_push), .q_data_o(fifo_wdata), .q_full_i(fifo_full)
  );

  sclse_fifo #(.WIDTH(ACC_WIDTH + 33)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(fifo_push), .wdata_i(fifo_wdata), .full_o(fifo_full),
    .pop_i(fifo_pop), .empty_o(fifo_empty), .rdata_o(fifo_rdata)
  );

  sclse_back #(.FRAC_BITS(FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .q_empty_i(fifo_empty), .q_data_i(fifo_rdata), .q_pop_o(fifo_pop),
    .empty, .pop, .data_o
  );

  // The front keeps offering its term while the queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push && fifo_full |=> fifo_push)
    else $error("term dropped while queue full");

  // The back never reads an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_pop && fifo_empty))
    else $error("pop from empty queue");

  // A minus-infinity result carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && data_o.minus_infinity |-> data_o.sum_out == 32'sd0)
    else $error("minus-infinity result with nonzero value");

endmodule
`default_nettype wire
